[hw/rtl/hashed_search_state_table_defines.svh]
// assertion macros for the hashed search-state table
`ifndef HASHED_SEARCH_STATE_TABLE_DEFINES_SVH
`define HASHED_SEARCH_STATE_TABLE_DEFINES_SVH

// property checked on every clock edge outside reset
`define HSST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked on every clock edge outside reset
`define HSST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication checked on every clock edge outside reset
`define HSST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/hsst_pkg.sv]
// shared constants and types of the hashed search-state table
package hsst_pkg;

  localparam int unsigned SLOT_COUNT = 16384;
  localparam int unsigned SLOT_BITS  = $clog2(SLOT_COUNT);
  localparam int unsigned OCC_W      = SLOT_BITS + 1;
  // smallest count at which occ*5 >= SLOT_COUNT*3
  localparam int unsigned LOAD_MAX   = (SLOT_COUNT * 3 + 4) / 5;

  localparam int unsigned KEY_W    = 64;
  localparam int unsigned COST_W   = 32;
  localparam int unsigned SLOT_O_W = 14;
  localparam int unsigned OCC_O_W  = 15;

  localparam logic [KEY_W-1:0]  EMPTY_KEY = '1;
  localparam logic [COST_W-1:0] NO_COST   = '1;
  localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;

  typedef enum logic [1:0] {
    OP_FIND   = 2'd0,
    OP_UPSERT = 2'd1,
    OP_MARK   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef struct packed {
    logic                found;
    logic [SLOT_O_W-1:0] slot;
    logic [COST_W-1:0]   cost;
    logic [KEY_W-1:0]    parent;
    logic                expanded;
    logic                status;
    logic [OCC_O_W-1:0]  occupied;
  } res_t;

endpackage

[hw/rtl/hsst_ram.sv]
// single-port synchronous ram with registered read
module hsst_ram #(
  parameter int unsigned ADDR_W = 14,
  parameter int unsigned DATA_W = 64
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/hsst_hash.sv]
// murmur3 fmix64 finalizer on one shared 32x32 multiplier, home slot out
module hsst_hash (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [hsst_pkg::KEY_W-1:0]    key_i,
  output logic                          done_o,
  output logic [hsst_pkg::SLOT_BITS-1:0] home_o
);
  import hsst_pkg::*;

  logic        run_q, run_d;
  logic        phase_q, phase_d;
  logic [1:0]  sub_q, sub_d;
  logic        done_q, done_d;
  logic [63:0] v_q, v_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] prod_q, prod_d;
  logic [63:0] cst;
  logic [31:0] mul_a, mul_b;
  logic [63:0] fin;

  assign cst = phase_q ? MIX_C2 : MIX_C1;

  always_comb begin
    unique case (sub_q)
      2'd0:    begin mul_a = v_q[31:0];  mul_b = cst[31:0];  end
      2'd1:    begin mul_a = v_q[31:0];  mul_b = cst[63:32]; end
      default: begin mul_a = v_q[63:32]; mul_b = cst[31:0];  end
    endcase
  end

  assign fin = {acc_q[63:32] + prod_q[31:0], acc_q[31:0]};

  always_comb begin
    run_d   = run_q;
    phase_d = phase_q;
    sub_d   = sub_q;
    done_d  = 1'b0;
    v_d     = v_q;
    acc_d   = acc_q;
    prod_d  = prod_q;
    if (start_i && !run_q) begin
      run_d   = 1'b1;
      phase_d = 1'b0;
      sub_d   = 2'd0;
      v_d     = key_i ^ (key_i >> 33);
    end else if (run_q) begin
      prod_d = {32'd0, mul_a} * {32'd0, mul_b};
      sub_d  = sub_q + 2'd1;
      unique case (sub_q)
        2'd0: ;
        2'd1: acc_d = prod_q;
        2'd2: acc_d = {acc_q[63:32] + prod_q[31:0], acc_q[31:0]};
        default: begin
          v_d     = fin ^ (fin >> 33);
          phase_d = 1'b1;
          if (phase_q) begin
            run_d  = 1'b0;
            done_d = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      phase_q <= 1'b0;
      sub_q   <= 2'd0;
      done_q  <= 1'b0;
    end else begin
      run_q   <= run_d;
      phase_q <= phase_d;
      sub_q   <= sub_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
  end

  assign done_o = done_q;
  assign home_o = v_q[SLOT_BITS-1:0];

endmodule

[hw/rtl/hashed_search_state_table.sv]
// top level of the hashed search-state table
//
//  port group        dir  handshake
//  request           in   start_i with busy_o low
//  result            out  done_o for one cycle, no backpressure
//
//  find and upsert: accept, hash on the shared multiplier, then for each probed
//  slot a key ram read, then a check and write back.
//  mark: accept, slot read, then check and write back. find or upsert of the empty key: answered at accept.
//  clear: one key ram row per cycle over all SLOT_COUNT (16384) rows, result at its end.
//  after reset the same clearing pass runs with busy_o high.
//  results cannot be stalled; busy_o is low only between requests.
module hashed_search_state_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  hsst_pkg::op_e                operation_i,
  input  logic [hsst_pkg::KEY_W-1:0]   state_key_i,
  input  logic [hsst_pkg::COST_W-1:0]  cost_value_i,
  input  logic [hsst_pkg::KEY_W-1:0]   parent_value_i,
  input  logic [hsst_pkg::SLOT_O_W-1:0] slot_index_i,
  output logic                         done_o,
  output logic                         found_o,
  output logic [hsst_pkg::SLOT_O_W-1:0] slot_out_o,
  output logic [hsst_pkg::COST_W-1:0]  cost_out_o,
  output logic [hsst_pkg::KEY_W-1:0]   parent_out_o,
  output logic                         expanded_out_o,
  output logic                         status_o,
  output logic [hsst_pkg::OCC_O_W-1:0] occupied_o
);
  import hsst_pkg::*;

  `include "hashed_search_state_table_defines.svh"

  typedef enum logic [4:0] {
    ST_CLR  = 5'b00001,
    ST_IDLE = 5'b00010,
    ST_HASH = 5'b00100,
    ST_RD   = 5'b01000,
    ST_CHK  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic [KEY_W-1:0]     key_q, key_d;
  logic [COST_W-1:0]    cost_q, cost_d;
  logic [KEY_W-1:0]     parent_q, parent_d;
  logic [SLOT_BITS-1:0] addr_q, addr_d;
  logic [SLOT_BITS-1:0] clr_idx_q, clr_idx_d;
  logic                 clr_res_q, clr_res_d;
  logic [OCC_W-1:0]     occ_q, occ_d;
  logic                 done_q, done_d;
  res_t                 res_q, res_d;

  logic                 hash_start;
  logic                 hash_done;
  logic [SLOT_BITS-1:0] home;

  logic                     key_we;
  logic [SLOT_BITS-1:0]     key_addr;
  logic [KEY_W:0]           key_wdata, key_rdata;
  logic                     ent_we;
  logic [COST_W+KEY_W-1:0]  ent_wdata, ent_rdata;

  logic [KEY_W-1:0] rd_key;
  logic             rd_flag;
  logic             rd_empty, rd_hit;

  hsst_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(hash_start),
    .key_i  (key_q),
    .done_o (hash_done),
    .home_o (home)
  );

  hsst_ram #(.ADDR_W(SLOT_BITS), .DATA_W(KEY_W + 1)) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .addr_i (key_addr),
    .wdata_i(key_wdata),
    .rdata_o(key_rdata)
  );

  hsst_ram #(.ADDR_W(SLOT_BITS), .DATA_W(COST_W + KEY_W)) u_ent_ram (
    .clk_i  (clk_i),
    .we_i   (ent_we),
    .addr_i (addr_q),
    .wdata_i(ent_wdata),
    .rdata_o(ent_rdata)
  );

  assign rd_key   = key_rdata[KEY_W-1:0];
  assign rd_flag  = key_rdata[KEY_W];
  assign rd_empty = (rd_key == EMPTY_KEY);
  assign rd_hit   = (rd_key == key_q);

  function automatic res_t none_res(logic st, logic [OCC_W-1:0] occ);
    res_t r;
    r.found    = 1'b0;
    r.slot     = '0;
    r.cost     = NO_COST;
    r.parent   = EMPTY_KEY;
    r.expanded = 1'b0;
    r.status   = st;
    r.occupied = OCC_O_W'(occ);
    return r;
  endfunction

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    key_d      = key_q;
    cost_d     = cost_q;
    parent_d   = parent_q;
    addr_d     = addr_q;
    clr_idx_d  = clr_idx_q;
    clr_res_d  = clr_res_q;
    occ_d      = occ_q;
    done_d     = 1'b0;
    res_d      = res_q;
    hash_start = 1'b0;
    key_we     = 1'b0;
    key_addr   = addr_q;
    key_wdata  = {1'b0, key_q};
    ent_we     = 1'b0;
    ent_wdata  = {parent_q, cost_q};

    unique case (state_q)
      ST_CLR: begin
        key_we    = 1'b1;
        key_addr  = clr_idx_q;
        key_wdata = {1'b0, EMPTY_KEY};
        clr_idx_d = clr_idx_q + 1'b1;
        if (clr_idx_q == SLOT_BITS'(SLOT_COUNT - 1)) begin
          occ_d   = '0;
          state_d = ST_IDLE;
          if (clr_res_q) begin
            done_d = 1'b1;
            res_d  = none_res(1'b0, '0);
          end
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          op_d     = operation_i;
          key_d    = state_key_i;
          cost_d   = cost_value_i;
          parent_d = parent_value_i;
          unique case (operation_i)
            OP_FIND, OP_UPSERT: begin
              if (state_key_i == EMPTY_KEY) begin
                done_d = 1'b1;
                res_d  = none_res(1'b0, occ_q);
              end else begin
                state_d = ST_HASH;
              end
            end
            OP_MARK: begin
              if (32'(slot_index_i) < SLOT_COUNT) begin
                addr_d  = SLOT_BITS'(slot_index_i);
                state_d = ST_RD;
              end else begin
                done_d = 1'b1;
                res_d  = none_res(1'b0, occ_q);
              end
            end
            default: begin
              clr_idx_d = '0;
              clr_res_d = 1'b1;
              state_d   = ST_CLR;
            end
          endcase
        end
      end
      ST_HASH: begin
        // key_q is loaded, so the hash starts on the first cycle here
        // and is not restarted on the cycle its home slot is taken
        hash_start = !hash_done;
        if (hash_done) begin
          addr_d  = home;
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_CHK;
      end
      default: begin
        res_d.slot   = SLOT_O_W'(addr_q);
        res_d.status = 1'b0;
        unique case (op_q)
          OP_MARK: begin
            state_d = ST_IDLE;
            done_d  = 1'b1;
            if (rd_empty) begin
              res_d = none_res(1'b0, occ_q);
            end else begin
              key_we         = 1'b1;
              key_wdata      = {1'b1, rd_key};
              res_d.found    = 1'b1;
              res_d.cost     = ent_rdata[COST_W-1:0];
              res_d.parent   = ent_rdata[COST_W+KEY_W-1:COST_W];
              res_d.expanded = 1'b1;
              res_d.occupied = OCC_O_W'(occ_q);
            end
          end
          OP_UPSERT: begin
            priority if (rd_empty) begin
              state_d = ST_IDLE;
              done_d  = 1'b1;
              if (occ_q >= OCC_W'(LOAD_MAX)) begin
                res_d = none_res(1'b1, occ_q);
              end else begin
                key_we         = 1'b1;
                ent_we         = 1'b1;
                occ_d          = occ_q + 1'b1;
                res_d.found    = 1'b0;
                res_d.cost     = cost_q;
                res_d.parent   = parent_q;
                res_d.expanded = 1'b0;
                res_d.occupied = OCC_O_W'(occ_q + 1'b1);
              end
            end else if (rd_hit) begin
              state_d        = ST_IDLE;
              done_d         = 1'b1;
              ent_we         = 1'b1;
              res_d.found    = 1'b1;
              res_d.cost     = cost_q;
              res_d.parent   = parent_q;
              res_d.expanded = rd_flag;
              res_d.occupied = OCC_O_W'(occ_q);
            end else begin
              addr_d  = addr_q + 1'b1;
              state_d = ST_RD;
            end
          end
          default: begin
            priority if (rd_empty) begin
              state_d = ST_IDLE;
              done_d  = 1'b1;
              res_d   = none_res(1'b0, occ_q);
            end else if (rd_hit) begin
              state_d        = ST_IDLE;
              done_d         = 1'b1;
              res_d.found    = 1'b1;
              res_d.cost     = ent_rdata[COST_W-1:0];
              res_d.parent   = ent_rdata[COST_W+KEY_W-1:COST_W];
              res_d.expanded = rd_flag;
              res_d.occupied = OCC_O_W'(occ_q);
            end else begin
              // linear probe, wraps at the top slot
              addr_d  = addr_q + 1'b1;
              state_d = ST_RD;
            end
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLR;
      clr_idx_q <= '0;
      clr_res_q <= 1'b0;
      occ_q     <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_idx_q <= clr_idx_d;
      clr_res_q <= clr_res_d;
      occ_q     <= occ_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    cost_q   <= cost_d;
    parent_q <= parent_d;
    addr_q   <= addr_d;
    res_q    <= res_d;
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign found_o        = res_q.found;
  assign slot_out_o     = res_q.slot;
  assign cost_out_o     = res_q.cost;
  assign parent_out_o   = res_q.parent;
  assign expanded_out_o = res_q.expanded;
  assign status_o       = res_q.status;
  assign occupied_o     = res_q.occupied;

  `HSST_ASSERT(a_occ_limit, occ_q <= OCC_W'(LOAD_MAX), "occupancy above load limit")
  `HSST_ASSERT_IMP(a_key_wr_state, key_we, (state_q == ST_CLR) || (state_q == ST_CHK), "key ram written outside sweep or check")
  `HSST_ASSERT_NXT(a_occ_step, state_q != ST_CLR, (occ_q == $past(occ_q)) || (occ_q == $past(occ_q) + 1'b1), "occupancy moved by more than one insert")
  `HSST_ASSERT_IMP(a_done_idle, done_o, !busy_o, "result shown while busy")

endmodule

[dv/hashed_search_state_table_test.sv]
// testbench of the hashed search-state table: directed table and random phases
`timescale 1ns / 100ps

module hashed_search_state_table_test;
  import hsst_pkg::*;

  localparam int unsigned WATCH_LIMIT = 4 * SLOT_COUNT + 8000;

  typedef struct {
    op_e               op;
    logic [KEY_W-1:0]  key;
    logic [COST_W-1:0] cost;
    logic [KEY_W-1:0]  parent;
    logic [13:0]       sidx;
    bit                typed;
    res_t              want;
  } request_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                busy_o;
  op_e                 operation_i = OP_FIND;
  logic [KEY_W-1:0]    state_key_i = '0;
  logic [COST_W-1:0]   cost_value_i = '0;
  logic [KEY_W-1:0]    parent_value_i = '0;
  logic [SLOT_O_W-1:0] slot_index_i = '0;
  logic                done_o, found_o, expanded_out_o, status_o;
  logic [SLOT_O_W-1:0] slot_out_o;
  logic [COST_W-1:0]   cost_out_o;
  logic [KEY_W-1:0]    parent_out_o;
  logic [OCC_O_W-1:0]  occupied_o;

  hashed_search_state_table i_dut (.*);

  always #6 clk_i = ~clk_i;

  // shadow copy of the table
  logic [KEY_W-1:0]  sh_key[SLOT_COUNT];
  logic [COST_W-1:0] sh_cost[SLOT_COUNT];
  logic [KEY_W-1:0]  sh_parent[SLOT_COUNT];
  bit                sh_flag[SLOT_COUNT];
  int unsigned       sh_count;

  res_t              pending_results[$];
  logic [KEY_W-1:0]  key_pool[$];
  request_t          dir_rows[$];
  int unsigned       n_items, n_results, n_clears, n_refused, n_errors;
  int unsigned       idle_cycles;
  int                gap_pct = 15;

  function automatic logic [13:0] home_of(logic [63:0] k);
    logic [63:0] v;
    v = k;
    v ^= v >> 33;
    v = v * MIX_C1;
    v ^= v >> 33;
    v = v * MIX_C2;
    v ^= v >> 33;
    return v[13:0];
  endfunction

  function automatic bit lookup(logic [63:0] k, output int unsigned pos);
    int unsigned idx;
    idx = home_of(k);
    pos = idx;
    for (int n = 0; n < SLOT_COUNT; n++) begin
      if (sh_key[idx] == EMPTY_KEY) begin
        pos = idx;
        return 1'b0;
      end
      if (sh_key[idx] == k) begin
        pos = idx;
        return 1'b1;
      end
      idx = (idx + 1 == SLOT_COUNT) ? 0 : idx + 1;
    end
    return 1'b0;
  endfunction

  function automatic void wipe_table();
    for (int i = 0; i < SLOT_COUNT; i++) begin
      sh_key[i] = EMPTY_KEY;
      sh_cost[i] = '0;
      sh_parent[i] = '0;
      sh_flag[i] = 1'b0;
    end
    sh_count = 0;
    key_pool.delete();
  endfunction

  function automatic void add_row(request_t q);
    dir_rows.insert(dir_rows.size(), q);
  endfunction

  function automatic res_t no_entry(bit st);
    res_t r;
    r = '{found: 1'b0, slot: '0, cost: NO_COST, parent: EMPTY_KEY, expanded: 1'b0,
          status: st, occupied: OCC_O_W'(sh_count)};
    return r;
  endfunction

  function automatic res_t entry_of(int unsigned s, bit f);
    res_t r;
    r = '{found: f, slot: SLOT_O_W'(s), cost: sh_cost[s], parent: sh_parent[s],
          expanded: sh_flag[s], status: 1'b0, occupied: OCC_O_W'(sh_count)};
    return r;
  endfunction

  // applies one request to the shadow table and returns its result
  function automatic res_t table_apply(request_t q);
    int unsigned pos;
    bit hit;
    case (q.op)
      OP_FIND: begin
        if (q.key != EMPTY_KEY && lookup(q.key, pos)) return entry_of(pos, 1'b1);
        return no_entry(1'b0);
      end
      OP_UPSERT: begin
        if (q.key == EMPTY_KEY) return no_entry(1'b0);
        hit = lookup(q.key, pos);
        if (hit) begin
          sh_cost[pos] = q.cost;
          sh_parent[pos] = q.parent;
          return entry_of(pos, 1'b1);
        end
        if (sh_count * 5 >= SLOT_COUNT * 3 || sh_key[pos] != EMPTY_KEY) begin
          n_refused++;
          return no_entry(1'b1);
        end
        sh_key[pos] = q.key;
        sh_cost[pos] = q.cost;
        sh_parent[pos] = q.parent;
        sh_flag[pos] = 1'b0;
        sh_count++;
        key_pool.insert(key_pool.size(), q.key);
        return entry_of(pos, 1'b0);
      end
      OP_MARK: begin
        if (q.sidx < SLOT_COUNT && sh_key[q.sidx] != EMPTY_KEY) begin
          sh_flag[q.sidx] = 1'b1;
          return entry_of(q.sidx, 1'b1);
        end
        return no_entry(1'b0);
      end
      default: begin
        wipe_table();
        n_clears++;
        return no_entry(1'b0);
      end
    endcase
  endfunction

  function automatic request_t mk(op_e op, logic [63:0] k, logic [31:0] c, logic [63:0] p,
                                  logic [13:0] s);
    request_t q;
    q = '{op: op, key: k, cost: c, parent: p, sidx: s, typed: 1'b0, want: '0};
    return q;
  endfunction

  function automatic request_t mk_typed(op_e op, logic [63:0] k, logic [13:0] s);
    request_t q;
    q = mk(op, k, '0, '0, s);
    q.typed = 1'b1;
    q.want = '{found: 1'b0, slot: '0, cost: NO_COST, parent: EMPTY_KEY, expanded: 1'b0,
               status: 1'b0, occupied: '0};
    return q;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] key_with_home(logic [13:0] h, logic [63:0] skip);
    logic [63:0] k;
    do k = rand64(); while (home_of(k) != h || k == skip || k == EMPTY_KEY);
    return k;
  endfunction

  function automatic request_t random_request(int clear_pct);
    request_t q;
    int unsigned pos, pick;
    logic [31:0] c;
    pick = $urandom_range(99);
    c = $urandom();
    if (c == NO_COST) c = c - 1;
    q = mk(OP_FIND, rand64(), c, rand64(), 14'($urandom()));
    if (q.key == EMPTY_KEY) q.key = '0;
    if (key_pool.size() > 0 && $urandom_range(99) < 60)
      q.key = key_pool[$urandom_range(key_pool.size() - 1)];
    if ($urandom_range(9) == 0) q.parent = EMPTY_KEY;
    if (pick < clear_pct) q.op = OP_CLEAR;
    else if (pick < 45) q.op = OP_UPSERT;
    else if (pick < 78) q.op = OP_FIND;
    else begin
      q.op = OP_MARK;
      if (key_pool.size() > 0 && $urandom_range(99) < 65 && lookup(q.key, pos))
        q.sidx = 14'(pos);
    end
    return q;
  endfunction

  task automatic send_request(request_t q);
    res_t r;
    @(negedge clk_i);
    if ($urandom_range(99) < gap_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    start_i        <= 1'b1;
    operation_i    <= q.op;
    state_key_i    <= q.key;
    cost_value_i   <= q.cost;
    parent_value_i <= q.parent;
    slot_index_i   <= q.sidx;
    do @(posedge clk_i); while (busy_o);
    r = table_apply(q);
    pending_results.insert(pending_results.size(), q.typed ? q.want : r);
    n_items++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk_i);
  endtask

  function automatic void cmp(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: mismatch on %s, expected %h, actual %h", $time, name, want, got);
      n_errors++;
    end
  endfunction

  // result checker and no-progress watchdog
  always @(posedge clk_i) begin
    res_t w;
    if (rst_ni) begin
      if (done_o) begin
        n_results++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, actual slot %h", $time, slot_out_o);
          n_errors++;
        end else begin
          w = pending_results.pop_front();
          cmp("found", w.found, found_o);
          cmp("slot", w.slot, slot_out_o);
          cmp("cost", w.cost, cost_out_o);
          cmp("parent", w.parent, parent_out_o);
          cmp("expanded", w.expanded, expanded_out_o);
          cmp("status", w.status, status_o);
          cmp("occupied", w.occupied, occupied_o);
        end
      end
      if (done_o || (start_i && !busy_o)) idle_cycles <= 0;
      else if (idle_cycles + 1 >= WATCH_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [63:0] kw1, kw2, kc1, kc2, kmax;
    idle_cycles = 0;
    wipe_table();
    kmax = EMPTY_KEY - 1;
    kw1 = key_with_home(14'h3fff, EMPTY_KEY);
    kw2 = key_with_home(14'h3fff, kw1);
    kc1 = key_with_home(14'd777, EMPTY_KEY);
    kc2 = key_with_home(14'd777, kc1);

    add_row(mk_typed(OP_FIND, '0, '0));
    add_row(mk_typed(OP_FIND, EMPTY_KEY, '0));
    add_row(mk_typed(OP_UPSERT, EMPTY_KEY, '0));
    add_row(mk_typed(OP_MARK, '0, '0));
    add_row(mk_typed(OP_MARK, '0, 14'h3fff));
    add_row(mk(OP_UPSERT, '0, '0, '0, '0));
    add_row(mk(OP_UPSERT, kmax, NO_COST - 1, EMPTY_KEY, '0));
    add_row(mk(OP_FIND, '0, '0, '0, '0));
    add_row(mk(OP_FIND, kmax, '0, '0, '0));
    add_row(mk(OP_UPSERT, '0, 32'h5a5a_a5a5, 64'h0123_4567_89ab_cdef, '0));
    // two keys homed on the last slot: the second wraps to slot 0 or beyond
    add_row(mk(OP_UPSERT, kw1, 32'd7, kc1, '0));
    add_row(mk(OP_UPSERT, kw2, 32'd9, kw1, '0));
    add_row(mk(OP_FIND, kw2, '0, '0, '0));
    add_row(mk(OP_MARK, '0, '0, '0, 14'h3fff));
    add_row(mk(OP_MARK, '0, '0, '0, '0));
    add_row(mk(OP_UPSERT, kw1, 32'd11, EMPTY_KEY, '0));
    add_row(mk(OP_UPSERT, kc1, 32'd1, '0, '0));
    add_row(mk(OP_UPSERT, kc2, 32'd2, EMPTY_KEY - 1, '0));
    add_row(mk(OP_FIND, kc2, '0, '0, '0));
    add_row(mk(OP_MARK, '0, '0, '0, 14'd778));
    add_row(mk_typed(OP_CLEAR, '0, '0));
    add_row(mk_typed(OP_FIND, kw1, '0));
    add_row(mk(OP_UPSERT, rand64() >> 1, $urandom() >> 1, rand64(), '0));

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_request(dir_rows[i]);
    drain();

    // random mix with a stretch of back-to-back requests in the middle
    for (int i = 0; i < 1200; i++) begin
      gap_pct = (i >= 400 && i < 700) ? 0 : 15;
      send_request(random_request(1));
    end
    drain();

    send_request(mk(OP_CLEAR, '0, '0, '0, '0));
    for (int i = 0; i < 40; i++) send_request(random_request(0));
    drain();

    repeat (50) @(posedge clk_i);
    $display("covered %0d requests and %0d results: %0d clears, %0d refused inserts",
             n_items, n_results, n_clears, n_refused);
    $display("probes wrapping past the top slot, marks, reserved keys and a gapless stretch");
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
